>>> sv/bprp_pkg.sv
// shared types and constants of the button program recorder and player
package bprp_pkg;

    typedef enum logic [3:0] {
        ACT_NONE  = 4'd0,
        ACT_ACK   = 4'd1,
        ACT_DONE  = 4'd2,
        ACT_ERROR = 4'd3,
        ACT_EMPTY = 4'd4,
        ACT_TUNE  = 4'd5,
        ACT_FWD   = 4'd6,
        ACT_BACK  = 4'd7,
        ACT_LEFT  = 4'd8,
        ACT_RIGHT = 4'd9,
        ACT_WAIT  = 4'd10,
        ACT_SONG  = 4'd11
    } action_t;

    typedef enum logic [1:0] {
        CONT_NONE  = 2'd0,
        CONT_START = 2'd1,
        CONT_STEP  = 2'd2
    } cont_t;

    localparam logic [2:0] KEY_FWD   = 3'd0;
    localparam logic [2:0] KEY_LEFT  = 3'd1;
    localparam logic [2:0] KEY_START = 3'd2;
    localparam logic [2:0] KEY_RIGHT = 3'd3;
    localparam logic [2:0] KEY_BACK  = 3'd4;
    localparam logic [2:0] KEY_OP1   = 3'd5;
    localparam logic [2:0] KEY_OP2   = 3'd6;
    localparam logic [2:0] KEY_CLEAR = 3'd7;

    localparam int CLEAR_BIT = 7;
    localparam logic [6:0] MUSIC_MASK = 7'h7f;

    // song from position: floor mod of y by Y_MOD, plus Y_MOD times x
    localparam int Y_MOD = 5;
    localparam logic [8:0] Y_LIFT = 9'd130;
    localparam int POS_SPAN = 640;

    localparam logic [7:0] STEP_X [4] = '{8'h00, 8'h01, 8'h00, 8'hff};
    localparam logic [7:0] STEP_Y [4] = '{8'h01, 8'h00, 8'hff, 8'h00};

    typedef struct packed {
        logic       req_type;
        logic [2:0] button;
        logic       pressed;
        logic [7:0] held_buttons;
    } req_word_t;

    typedef struct packed {
        action_t           action;
        logic [2:0]        song_number;
        logic              stop_all;
        logic signed [7:0] pos_x;
        logic signed [7:0] pos_y;
        logic [1:0]        heading;
        logic              running;
        logic              music_mode;
    } rsp_word_t;

endpackage

>>> sv/bprp_chan_if.sv
// valid/ready channel carrying one word per handshake
interface bprp_chan_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/button_program_recorder_player.sv
// button program recorder and player for a floor robot
//
// Takes one event word per cycle on req (button press/release or action finished) and
// answers with at most one word on rsp, held in an output register: a new event is taken
// whenever that register is empty or being read in the same cycle, so the sustained rate is
// one event per clock and the answer appears in the cycle after the event. Buttons are recorded
// into a PROGRAM_DEPTH entry command memory; the command of the next step is read from that
// memory into a register ahead of time, so a finished event plays its step without waiting.
// Position and heading are tracked during a run; songs are picked modulo SONG_COUNT. No
// clearing pass after reset: memory entries are used only below the recorded count.
module button_program_recorder_player #(
    parameter int PROGRAM_DEPTH = 32,
    parameter int SONG_COUNT    = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    bprp_chan_if.sink   req,
    bprp_chan_if.source rsp
);

    localparam int CW = $clog2(PROGRAM_DEPTH + 1);
    localparam int AW = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
    localparam int SONG_BIAS =
        ((bprp_pkg::POS_SPAN + SONG_COUNT - 1) / SONG_COUNT) * SONG_COUNT;

    logic [2:0]          mem [PROGRAM_DEPTH];
    logic [2:0]          cmd_reg;

    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       step_reg, step_next;
    logic                run_reg, run_next;
    logic [7:0]          x_reg, x_next;
    logic [7:0]          y_reg, y_next;
    logic [1:0]          dir_reg, dir_next;
    logic                mode_reg, mode_next;
    bprp_pkg::cont_t     cont_reg, cont_next;

    logic                rsp_valid_reg;
    bprp_pkg::rsp_word_t rsp_word_reg;

    logic                req_accept;
    bprp_pkg::action_t   act;
    logic                stopped;
    logic                do_write;
    logic                play;
    logic [CW-1:0]       play_idx;
    logic [CW-1:0]       rd_idx;

    logic                start_fire;
    logic [7:0]          x_base, y_base;
    logic [1:0]          dir_base;

    // song unit
    logic [5:0]          s_lo_tab [64];
    logic [5:0]          s_hi_tab [32];
    logic [2:0]          y_lo_tab [64];
    logic [2:0]          y_hi_tab [8];
    logic [8:0]          y_lift;
    logic [3:0]          y_sum;
    logic [2:0]          y_rem;
    logic signed [10:0]  x_wide, five_x;
    logic [10:0]         u_pos, song_u;
    logic [6:0]          s_sum;
    logic [5:0]          song_rem;
    logic [6:0]          music_bits;

    for (genvar i = 0; i < 64; i++) begin : g_lo_tab
        assign s_lo_tab[i] = 6'(i % SONG_COUNT);
        assign y_lo_tab[i] = 3'(i % bprp_pkg::Y_MOD);
    end
    for (genvar i = 0; i < 32; i++) begin : g_s_hi_tab
        assign s_hi_tab[i] = 6'((i * 64) % SONG_COUNT);
    end
    for (genvar i = 0; i < 8; i++) begin : g_y_hi_tab
        assign y_hi_tab[i] = 3'((i * 64) % bprp_pkg::Y_MOD);
    end

    assign req_accept = req.valid && req.ready;
    assign req.ready  = !rsp_valid_reg || rsp.ready;

    // a start continuation clears position and heading before the first step
    assign start_fire = req.data.req_type && (cont_reg == bprp_pkg::CONT_START);
    assign x_base     = start_fire ? 8'h00 : x_reg;
    assign y_base     = start_fire ? 8'h00 : y_reg;
    assign dir_base   = start_fire ? 2'd0 : dir_reg;

    assign y_lift = {y_base[7], y_base} + bprp_pkg::Y_LIFT;
    assign y_sum  = {1'b0, y_hi_tab[y_lift[8:6]]} + {1'b0, y_lo_tab[y_lift[5:0]]};
    assign y_rem  = (y_sum >= 4'(bprp_pkg::Y_MOD)) ? 3'(y_sum - 4'(bprp_pkg::Y_MOD))
                                                   : y_sum[2:0];

    assign x_wide = {{3{x_base[7]}}, x_base};
    assign five_x = (x_wide <<< 2) + x_wide;
    assign u_pos  = 11'(five_x) + {8'b0, y_rem} + 11'(SONG_BIAS);

    assign music_bits = req.data.held_buttons[6:0] & bprp_pkg::MUSIC_MASK;
    assign song_u     = req.data.req_type ? u_pos : {4'b0, 7'(music_bits - 7'd1)};

    assign s_sum    = {1'b0, s_hi_tab[song_u[10:6]]} + {1'b0, s_lo_tab[song_u[5:0]]};
    assign song_rem = (s_sum >= 7'(SONG_COUNT)) ? 6'(s_sum - 7'(SONG_COUNT)) : s_sum[5:0];

    always_comb
    begin
        count_next = count_reg;
        step_next  = step_reg;
        run_next   = run_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        dir_next   = dir_reg;
        mode_next  = mode_reg;
        cont_next  = cont_reg;
        act        = bprp_pkg::ACT_NONE;
        stopped    = 1'b0;
        do_write   = 1'b0;
        play       = 1'b0;
        play_idx   = '0;

        if (req_accept)
        begin
            if (req.data.req_type)
            begin
                priority if (cont_reg == bprp_pkg::CONT_START)
                begin
                    stopped  = run_reg;
                    play     = 1'b1;
                    play_idx = '0;
                    x_next   = 8'h00;
                    y_next   = 8'h00;
                    dir_next = 2'd0;
                    run_next = 1'b1;
                end
                else if (cont_reg == bprp_pkg::CONT_STEP)
                begin
                    play     = 1'b1;
                    play_idx = step_reg + CW'(1);
                end
                else
                begin
                    play = 1'b0;
                end
            end
            else if (req.data.pressed)
            begin
                priority if (req.data.button != bprp_pkg::KEY_CLEAR
                             && req.data.held_buttons[bprp_pkg::CLEAR_BIT]
                             && (req.data.button == bprp_pkg::KEY_FWD
                                 || req.data.button == bprp_pkg::KEY_START))
                begin
                    stopped = run_reg;
                    if (run_reg)
                    begin
                        run_next  = 1'b0;
                        step_next = '0;
                    end
                    cont_next = bprp_pkg::CONT_NONE;
                    if (req.data.button == bprp_pkg::KEY_FWD)
                    begin
                        mode_next = 1'b1;
                        act       = bprp_pkg::ACT_TUNE;
                    end
                    else
                    begin
                        mode_next = 1'b0;
                        act       = bprp_pkg::ACT_EMPTY;
                    end
                end
                else if (mode_reg)
                begin
                    if (music_bits != 7'd0)
                    begin
                        act       = bprp_pkg::ACT_SONG;
                        cont_next = bprp_pkg::CONT_NONE;
                    end
                end
                else if (req.data.button == bprp_pkg::KEY_START)
                begin
                    priority if (run_reg)
                    begin
                        stopped   = 1'b1;
                        run_next  = 1'b0;
                        step_next = '0;
                        act       = bprp_pkg::ACT_ERROR;
                        cont_next = bprp_pkg::CONT_NONE;
                    end
                    else if (count_reg == '0)
                    begin
                        act       = bprp_pkg::ACT_EMPTY;
                        cont_next = bprp_pkg::CONT_NONE;
                    end
                    else
                    begin
                        act       = bprp_pkg::ACT_ACK;
                        cont_next = bprp_pkg::CONT_START;
                    end
                end
                else if (req.data.button == bprp_pkg::KEY_CLEAR)
                begin
                    stopped = run_reg;
                    if (run_reg)
                    begin
                        run_next  = 1'b0;
                        step_next = '0;
                    end
                    count_next = '0;
                    act        = bprp_pkg::ACT_EMPTY;
                    cont_next  = bprp_pkg::CONT_NONE;
                end
                else
                begin
                    if (count_reg < CW'(PROGRAM_DEPTH))
                    begin
                        do_write   = 1'b1;
                        count_next = count_reg + CW'(1);
                        act        = bprp_pkg::ACT_ACK;
                    end
                    else
                    begin
                        act = bprp_pkg::ACT_ERROR;
                    end
                    cont_next = bprp_pkg::CONT_NONE;
                end
            end
        end

        // step playback from the prefetched command
        if (play)
        begin
            if (play_idx >= count_reg || play_idx >= CW'(PROGRAM_DEPTH))
            begin
                run_next  = 1'b0;
                step_next = '0;
                cont_next = bprp_pkg::CONT_NONE;
                act       = bprp_pkg::ACT_DONE;
            end
            else
            begin
                step_next = play_idx;
                cont_next = bprp_pkg::CONT_STEP;
                unique case (cmd_reg)
                    bprp_pkg::KEY_RIGHT:
                    begin
                        dir_next = dir_base + 2'd1;
                        act      = bprp_pkg::ACT_RIGHT;
                    end
                    bprp_pkg::KEY_LEFT:
                    begin
                        dir_next = dir_base + 2'd3;
                        act      = bprp_pkg::ACT_LEFT;
                    end
                    bprp_pkg::KEY_FWD:
                    begin
                        x_next = x_base + bprp_pkg::STEP_X[dir_base];
                        y_next = y_base + bprp_pkg::STEP_Y[dir_base];
                        act    = bprp_pkg::ACT_FWD;
                    end
                    bprp_pkg::KEY_BACK:
                    begin
                        x_next = x_base - bprp_pkg::STEP_X[dir_base];
                        y_next = y_base - bprp_pkg::STEP_Y[dir_base];
                        act    = bprp_pkg::ACT_BACK;
                    end
                    bprp_pkg::KEY_OP1:
                    begin
                        act = bprp_pkg::ACT_WAIT;
                    end
                    bprp_pkg::KEY_OP2:
                    begin
                        act = bprp_pkg::ACT_SONG;
                    end
                    default:
                    begin
                        cont_next = bprp_pkg::CONT_NONE;
                        act       = bprp_pkg::ACT_NONE;
                    end
                endcase
            end
        end
    end

    // address of the command the next finished event will play
    assign rd_idx = (cont_next == bprp_pkg::CONT_START) ? '0 : step_next + CW'(1);

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[count_reg[AW-1:0]] <= req.data.button;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_idx < CW'(PROGRAM_DEPTH))
        begin
            cmd_reg <= mem[rd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            step_reg  <= '0;
            run_reg   <= 1'b0;
            x_reg     <= 8'h00;
            y_reg     <= 8'h00;
            dir_reg   <= 2'd0;
            mode_reg  <= 1'b0;
            cont_reg  <= bprp_pkg::CONT_NONE;
        end
        else
        begin
            count_reg <= count_next;
            step_reg  <= step_next;
            run_reg   <= run_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            dir_reg   <= dir_next;
            mode_reg  <= mode_next;
            cont_reg  <= cont_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (req_accept && act != bprp_pkg::ACT_NONE)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept && act != bprp_pkg::ACT_NONE)
        begin
            rsp_word_reg.action      <= act;
            rsp_word_reg.song_number <= (act == bprp_pkg::ACT_SONG) ? song_rem[2:0] : 3'd0;
            rsp_word_reg.stop_all    <= stopped;
            rsp_word_reg.pos_x       <= signed'(x_next);
            rsp_word_reg.pos_y       <= signed'(y_next);
            rsp_word_reg.heading     <= dir_next;
            rsp_word_reg.running     <= run_next;
            rsp_word_reg.music_mode  <= mode_next;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_word_reg;

    // a pending step always points at a recorded command
    a_step_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        cont_reg == bprp_pkg::CONT_STEP |-> step_reg < count_reg)
        else $error("step pointer beyond recorded program");

    // a start is only armed while no program runs and the recorded program is not empty
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cont_reg == bprp_pkg::CONT_START |-> !run_reg && count_reg != '0)
        else $error("start armed while running or with empty program");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(PROGRAM_DEPTH))
        else $error("command count beyond store depth");

    a_song_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_word_reg.action != bprp_pkg::ACT_SONG
        |-> rsp_word_reg.song_number == 3'd0)
        else $error("song number on a non-song word");

    // a word with no action is never presented
    a_no_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept && act == bprp_pkg::ACT_NONE && !rsp.ready |=> !rsp_valid_reg
        || $stable(rsp_word_reg))
        else $error("silent event changed the output word");

endmodule
